// ----- design/assert_macros.svh -----
// Assertion macros shared by the tag engine modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset
`define SACTE_ASSERT_ON(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tag engine assertion failed");

// Condition that must hold in the cycle after a trigger
`define SACTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("tag engine assertion failed");

`endif

// ----- design/sacte_pkg.sv -----
// Shared types, constants and helpers of the cache tag engine
`timescale 1ns / 1ps
package sacte_pkg;

	localparam int ADDR_W     = 32;
	localparam int LEN_W      = 13;
	localparam int CYC_W      = 16;
	localparam int STAT_W     = 13;
	localparam int LFSR_W     = 16;
	localparam int DIV_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY      = 2'd3;

	localparam logic CMD_ACCESS     = 1'b0;
	localparam logic CMD_INVALIDATE = 1'b1;
	localparam logic POLICY_RR      = 1'b0;
	localparam logic POLICY_LFSR    = 1'b1;

	localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_WALK,
		ST_RESOLVE,
		ST_MOD,
		ST_WRITE,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [LFSR_W-1:0] dividend;
		logic [DIV_W-1:0]  divisor;
	} mod_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [DIV_W-1:0] rem;
	} mod_rsp_t;

	// Right-shifting Fibonacci LFSR, taps 16,14,13,11
	function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
		logic b;
		b = v[0] ^ v[2] ^ v[3] ^ v[5];
		return {b, v[LFSR_W-1:1]};
	endfunction

endpackage

// ----- design/sacte_tag_mem.sv -----
// Per-set line store: valid bits, tags and round-robin pointer
`timescale 1ns / 1ps
module sacte_tag_mem #(
	parameter int SETS  = 1024,
	parameter int WAYS  = 8,
	parameter int SET_W = 10,
	parameter int WAY_W = 3
) (
	input  logic                                  clk,
	input  logic                                  rd_en,
	input  logic [SET_W-1:0]                      rd_addr,
	output logic [WAYS-1:0]                       rd_valid,
	output logic [WAYS-1:0][sacte_pkg::ADDR_W-1:0] rd_tags,
	output logic [WAY_W-1:0]                      rd_rr,
	input  logic                                  wr_en,
	input  logic [SET_W-1:0]                      wr_addr,
	input  logic [WAYS-1:0]                       wr_valid,
	input  logic [WAYS-1:0][sacte_pkg::ADDR_W-1:0] wr_tags,
	input  logic [WAY_W-1:0]                      wr_rr
);

	logic [WAYS-1:0]                        valid_mem [SETS];
	logic [WAYS-1:0][sacte_pkg::ADDR_W-1:0] tag_mem   [SETS];
	logic [WAY_W-1:0]                       rr_mem    [SETS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			valid_mem[wr_addr] <= wr_valid;
			tag_mem[wr_addr]   <= wr_tags;
			rr_mem[wr_addr]    <= wr_rr;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_valid <= valid_mem[rd_addr];
			rd_tags  <= tag_mem[rd_addr];
			rd_rr    <= rr_mem[rd_addr];
		end
	end

endmodule

// ----- design/sacte_mod_unit.sv -----
// Bit-serial remainder unit for victim selection
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sacte_mod_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  sacte_pkg::mod_req_t req,
	output sacte_pkg::mod_rsp_t rsp
);

	localparam int STEP_W = $clog2(sacte_pkg::LFSR_W + 1);

	logic                           busy_q;
	logic                           done_q;
	logic [STEP_W-1:0]              step_q;
	logic [sacte_pkg::LFSR_W-1:0]   x_q;
	logic [sacte_pkg::DIV_W-1:0]    rem_q;
	logic [sacte_pkg::DIV_W-1:0]    div_q;
	logic [sacte_pkg::DIV_W:0]      trial;
	logic [sacte_pkg::DIV_W:0]      diff;

	assign trial = {rem_q, x_q[sacte_pkg::LFSR_W-1]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= STEP_W'(sacte_pkg::LFSR_W);
		end else begin
			done_q <= busy_q && (step_q == STEP_W'(1));
			if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring remainder, one dividend bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q   <= req.dividend;
			rem_q <= '0;
			div_q <= req.divisor;
		end else if (busy_q) begin
			x_q   <= {x_q[sacte_pkg::LFSR_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, div_q}) ? diff[sacte_pkg::DIV_W-1:0]
			                                   : trial[sacte_pkg::DIV_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	`SACTE_ASSERT_ON(a_rem_below_divisor, done_q |-> (rem_q < div_q))
	`SACTE_ASSERT_NEXT(a_start_busy, req.start, busy_q)

endmodule

// ----- design/set_assoc_cache_tag_engine_top.sv -----
// Top level of the set-associative cache tag engine
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Tag store of a set-associative cache with 32-bit byte addresses. Each transfer on the
// input channel is an access or a range invalidate; the engine walks every cache block
// the range touches, in address order, and returns one result transfer with the modelled
// cycle total and hit/miss/compulsory/conflict counts (all zero for an invalidate).
// Sequence: after reset a clearing pass writes every set with in_ready low. Afterwards
// each block is read, loaded and walked; the walk compares one way per cycle through a
// single tag comparator and, for an access, stops early on a hit, and a conflict miss
// waits for the bit-serial remainder unit that picks the victim (round-robin pointer or
// LFSR modulo ways). A finished result sits in the output register while the next item
// is accepted; the final FINISH step of an item waits while the previous result is still
// unaccepted. Configuration may be written only while the engine is idle; cfg_ready is
// always high.
module set_assoc_cache_tag_engine_top #(
	parameter int MAX_SETS = 1024,
	parameter int MAX_WAYS = 8,
	parameter int MAX_LEN  = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sacte_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sacte_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [sacte_pkg::ADDR_W-1:0]      address,
	input  logic [sacte_pkg::LEN_W-1:0]       length,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sacte_pkg::CYC_W-1:0]       cycles,
	output logic [sacte_pkg::STAT_W-1:0]      hits,
	output logic [sacte_pkg::STAT_W-1:0]      misses,
	output logic [sacte_pkg::STAT_W-1:0]      compulsory_misses,
	output logic [sacte_pkg::STAT_W-1:0]      conflict_misses
);

	localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W   = $clog2(MAX_WAYS + 1);
	localparam int IB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int AW     = sacte_pkg::ADDR_W;
	localparam int SW     = sacte_pkg::STAT_W;
	localparam int CW     = sacte_pkg::CYC_W;
	localparam int BLK_W  = sacte_pkg::LEN_W + 1;

	function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] x);
		return (x == '1) ? x : x + SW'(1);
	endfunction

	// configuration registers
	logic [2:0] ob_q;
	logic [3:0] ib_q;
	logic [3:0] ways_q;
	logic       policy_q;

	sacte_pkg::state_t state_q, state_d;

	logic [SET_W-1:0]  clr_q;
	logic              cmd_q;
	logic [AW-1:0]     base_q;
	logic [BLK_W-1:0]  blk_left_q;
	logic [AW-1:0]     tag_q;
	logic [SET_W-1:0]  set_q;
	logic [MAX_WAYS-1:0] valid_q;
	logic [WAY_W-1:0]  rr_q;
	logic [NW_W-1:0]   w_q;
	logic              hit_q;
	logic              empty_found_q;
	logic [WAY_W-1:0]  empty_q;
	logic              miss_q;
	logic [WAY_W-1:0]  victim_q;
	logic [sacte_pkg::LFSR_W-1:0] lfsr_q;
	logic [CW-1:0]     cyc_q;
	logic [SW-1:0]     hit_cnt_q, miss_cnt_q, comp_cnt_q, confl_cnt_q;
	logic              out_valid_q;
	logic [CW-1:0]     out_cyc_q;
	logic [SW-1:0]     out_hit_q, out_miss_q, out_comp_q, out_confl_q;

	// effective configuration
	logic [3:0]        ib_eff;
	logic [NW_W-1:0]   nw_eff;
	logic [5:0]        ways_ext;
	logic [AW-1:0]     blk_mask;
	logic [AW-1:0]     bsize;
	logic [7:0]        miss_cost;
	logic [sacte_pkg::LEN_W-1:0] len_eff;
	logic [BLK_W-1:0]  span;
	logic [BLK_W-1:0]  nblocks;
	logic [AW-1:0]     set_mask;
	logic [AW-1:0]     set_full;
	logic [4:0]        tag_sh;
	logic [AW-1:0]     tag_w;

	// walk and memory signals
	logic [WAY_W-1:0]  cur;
	logic              walk_match;
	logic              walk_last;
	logic              conflict_now;
	logic [CW:0]       cyc_sum;
	logic [sacte_pkg::LFSR_W-1:0] lfsr_step;
	logic [sacte_pkg::DIV_W-1:0]  rem_p1;

	logic              rd_en, wr_en;
	logic [SET_W-1:0]  rd_addr, wr_addr;
	logic [MAX_WAYS-1:0]       rd_valid, wr_valid;
	logic [MAX_WAYS-1:0][AW-1:0] rd_tags, wr_tags;
	logic [WAY_W-1:0]  rd_rr, wr_rr;

	sacte_pkg::mod_req_t mod_req;
	sacte_pkg::mod_rsp_t mod_rsp;

	// compare one bit wider so a set limit of 2^16 still clamps correctly
	assign ib_eff   = ({1'b0, ib_q} > 5'(IB_MAX)) ? 4'(IB_MAX) : ib_q;
	assign ways_ext = {2'b00, ways_q};
	always_comb begin
		if (ways_q == 4'd0) begin
			nw_eff = NW_W'(1);
		end else if (ways_ext > 6'(MAX_WAYS)) begin
			nw_eff = NW_W'(MAX_WAYS);
		end else begin
			nw_eff = NW_W'(ways_ext);
		end
	end

	assign bsize     = AW'(1) << ob_q;
	assign blk_mask  = bsize - AW'(1);
	assign miss_cost = (ob_q < 3'd2) ? 8'd4 : bsize[7:0];
	always_comb begin
		if (length == '0) begin
			len_eff = sacte_pkg::LEN_W'(1);
		end else if ({4'b0000, length} > 17'(MAX_LEN)) begin
			len_eff = sacte_pkg::LEN_W'(MAX_LEN);
		end else begin
			len_eff = length;
		end
	end
	assign span    = BLK_W'(address[6:0] & blk_mask[6:0]) + {1'b0, len_eff} - BLK_W'(1);
	assign nblocks = (span >> ob_q) + BLK_W'(1);

	// set index and tag of the current block
	assign set_mask = (AW'(1) << ib_eff) - AW'(1);
	assign set_full = (base_q >> ob_q) & set_mask;
	assign tag_sh   = 5'(ob_q) + 5'(ib_eff);
	assign tag_w    = base_q >> tag_sh;

	// one tag compare per cycle
	assign cur        = w_q[WAY_W-1:0];
	assign walk_match = valid_q[cur] && (rd_tags[cur] == tag_q);
	assign walk_last  = (w_q == nw_eff - NW_W'(1));
	assign conflict_now = (cmd_q == sacte_pkg::CMD_ACCESS) && !hit_q && !empty_found_q;
	assign cyc_sum    = {1'b0, cyc_q} + (hit_q ? (CW+1)'(1) : (CW+1)'(miss_cost));
	assign lfsr_step  = sacte_pkg::lfsr_next(lfsr_q);
	assign rem_p1     = mod_rsp.rem + sacte_pkg::DIV_W'(1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			sacte_pkg::ST_CLEAR: begin
				if (clr_q == SET_W'(MAX_SETS - 1)) state_d = sacte_pkg::ST_IDLE;
			end
			sacte_pkg::ST_IDLE: begin
				if (in_valid) state_d = sacte_pkg::ST_READ;
			end
			sacte_pkg::ST_READ:  state_d = sacte_pkg::ST_LOAD;
			sacte_pkg::ST_LOAD:  state_d = sacte_pkg::ST_WALK;
			sacte_pkg::ST_WALK: begin
				if ((cmd_q == sacte_pkg::CMD_ACCESS && walk_match) || walk_last) begin
					state_d = sacte_pkg::ST_RESOLVE;
				end
			end
			sacte_pkg::ST_RESOLVE: begin
				state_d = conflict_now ? sacte_pkg::ST_MOD : sacte_pkg::ST_WRITE;
			end
			sacte_pkg::ST_MOD: begin
				if (mod_rsp.done) state_d = sacte_pkg::ST_WRITE;
			end
			sacte_pkg::ST_WRITE: begin
				state_d = (blk_left_q == BLK_W'(1)) ? sacte_pkg::ST_FINISH
				                                    : sacte_pkg::ST_READ;
			end
			sacte_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = sacte_pkg::ST_IDLE;
			end
			default: state_d = sacte_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready         = 1'b0;
		rd_en            = 1'b0;
		rd_addr          = set_full[SET_W-1:0];
		wr_en            = 1'b0;
		wr_addr          = set_q;
		wr_valid         = valid_q;
		wr_rr            = rr_q;
		mod_req.start    = 1'b0;
		mod_req.divisor  = sacte_pkg::DIV_W'(nw_eff);
		mod_req.dividend = (policy_q == sacte_pkg::POLICY_RR)
		                   ? sacte_pkg::LFSR_W'(rr_q) : lfsr_step;
		for (int i = 0; i < MAX_WAYS; i++) begin
			wr_tags[i] = (miss_q && victim_q == WAY_W'(i)) ? tag_q : rd_tags[i];
		end
		case (state_q)
			sacte_pkg::ST_CLEAR: begin
				wr_en    = 1'b1;
				wr_addr  = clr_q;
				wr_valid = '0;
				wr_rr    = '0;
			end
			sacte_pkg::ST_IDLE:    in_ready = 1'b1;
			sacte_pkg::ST_READ:    rd_en = 1'b1;
			sacte_pkg::ST_RESOLVE: mod_req.start = conflict_now;
			sacte_pkg::ST_WRITE: begin
				wr_en = 1'b1;
				if (miss_q) wr_valid = valid_q | (MAX_WAYS'(1) << victim_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sacte_pkg::ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == sacte_pkg::ST_CLEAR) clr_q <= clr_q + SET_W'(1);
		end
	end

	// configuration, LFSR and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_q        <= 3'd4;
			ib_q        <= 4'd6;
			ways_q      <= 4'd4;
			policy_q    <= sacte_pkg::POLICY_RR;
			lfsr_q      <= sacte_pkg::LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					sacte_pkg::CFG_OFFSET_BITS: ob_q     <= cfg_data[2:0];
					sacte_pkg::CFG_INDEX_BITS:  ib_q     <= cfg_data;
					sacte_pkg::CFG_WAYS:        ways_q   <= cfg_data;
					sacte_pkg::CFG_POLICY:      policy_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == sacte_pkg::ST_RESOLVE && conflict_now &&
			    policy_q == sacte_pkg::POLICY_LFSR) begin
				lfsr_q <= lfsr_step;
			end
			if (state_q == sacte_pkg::ST_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// block walk datapath
	always_ff @(posedge clk) begin
		case (state_q)
			sacte_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd_q       <= cmd;
					base_q      <= address & ~blk_mask;
					blk_left_q  <= nblocks;
					cyc_q       <= '0;
					hit_cnt_q   <= '0;
					miss_cnt_q  <= '0;
					comp_cnt_q  <= '0;
					confl_cnt_q <= '0;
				end
			end
			sacte_pkg::ST_READ: begin
				tag_q <= tag_w;
				set_q <= set_full[SET_W-1:0];
			end
			sacte_pkg::ST_LOAD: begin
				valid_q       <= rd_valid;
				rr_q          <= rd_rr;
				w_q           <= '0;
				hit_q         <= 1'b0;
				empty_found_q <= 1'b0;
				miss_q        <= 1'b0;
			end
			sacte_pkg::ST_WALK: begin
				w_q <= w_q + NW_W'(1);
				if (cmd_q == sacte_pkg::CMD_INVALIDATE) begin
					if (walk_match) valid_q[cur] <= 1'b0;
				end else if (walk_match) begin
					hit_q <= 1'b1;
				end else if (!valid_q[cur] && !empty_found_q) begin
					empty_found_q <= 1'b1;
					empty_q       <= cur;
				end
			end
			sacte_pkg::ST_RESOLVE: begin
				if (cmd_q == sacte_pkg::CMD_ACCESS) begin
					cyc_q <= cyc_sum[CW] ? '1 : cyc_sum[CW-1:0];
					if (hit_q) begin
						hit_cnt_q <= sat_inc(hit_cnt_q);
					end else begin
						miss_q     <= 1'b1;
						miss_cnt_q <= sat_inc(miss_cnt_q);
						if (empty_found_q) begin
							victim_q   <= empty_q;
							comp_cnt_q <= sat_inc(comp_cnt_q);
						end else begin
							confl_cnt_q <= sat_inc(confl_cnt_q);
						end
					end
				end
			end
			sacte_pkg::ST_MOD: begin
				if (mod_rsp.done) begin
					victim_q <= mod_rsp.rem[WAY_W-1:0];
					if (policy_q == sacte_pkg::POLICY_RR) begin
						rr_q <= (rem_p1 == sacte_pkg::DIV_W'(nw_eff)) ? '0
						                                               : rem_p1[WAY_W-1:0];
					end
				end
			end
			sacte_pkg::ST_WRITE: begin
				blk_left_q <= blk_left_q - BLK_W'(1);
				base_q     <= base_q + bsize;
			end
			sacte_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					out_cyc_q   <= cyc_q;
					out_hit_q   <= hit_cnt_q;
					out_miss_q  <= miss_cnt_q;
					out_comp_q  <= comp_cnt_q;
					out_confl_q <= confl_cnt_q;
				end
			end
			default: ;
		endcase
	end

	sacte_tag_mem #(
		.SETS (MAX_SETS),
		.WAYS (MAX_WAYS),
		.SET_W(SET_W),
		.WAY_W(WAY_W)
	) u_tag_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_valid(rd_valid),
		.rd_tags (rd_tags),
		.rd_rr   (rd_rr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_valid(wr_valid),
		.wr_tags (wr_tags),
		.wr_rr   (wr_rr)
	);

	sacte_mod_unit u_mod_unit (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mod_req),
		.rsp   (mod_rsp)
	);

	assign cfg_ready         = 1'b1;
	assign out_valid         = out_valid_q;
	assign cycles            = out_cyc_q;
	assign hits              = out_hit_q;
	assign misses            = out_miss_q;
	assign compulsory_misses = out_comp_q;
	assign conflict_misses   = out_confl_q;

	`SACTE_ASSERT_ON(a_walk_in_range, (state_q == sacte_pkg::ST_WALK) |-> (w_q < nw_eff))
	`SACTE_ASSERT_ON(a_mod_active,
		(state_q == sacte_pkg::ST_MOD) |-> (mod_rsp.busy || mod_rsp.done))
	`SACTE_ASSERT_ON(a_blocks_left, (state_q == sacte_pkg::ST_READ) |-> (blk_left_q != '0))

endmodule
